// ===== hdl/value_noise_2d_sigmoid_unit_macros.svh =====
// assertion macros shared by the noise unit
`ifndef VALUE_NOISE_2D_SIGMOID_UNIT_MACROS_SVH
`define VALUE_NOISE_2D_SIGMOID_UNIT_MACROS_SVH

// condition must hold at every edge outside reset
`define VNS_ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("vns check failed");

// consequent must hold in the same cycle as the trigger
`define VNS_ASSERT_IMPLY(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("vns check failed");

`endif

// ===== hdl/vns_pkg.sv =====
`default_nettype none

package vns_pkg;

   // field formats
   localparam int COORD_W         = 48;
   localparam int COORD_FRAC_BITS = 16;
   localparam int OUT_FRAC_BITS   = 16;
   localparam int OUT_W           = 18;
   localparam int COS_TABLE_BITS  = 10;
   localparam int TABLE_SIZE      = 1 << COS_TABLE_BITS;
   localparam int HALF_TABLE      = TABLE_SIZE / 2;

   // lattice and hash
   localparam int IPART_W = 32;
   localparam int HASH_W  = 31;
   localparam int CORNERS = 4;
   localparam logic [31:0] HASH_Y_MUL = 32'd57;
   localparam int          HASH_SHIFT = 13;
   localparam logic [31:0] HASH_SQ_MUL = 32'd60493;
   localparam logic [31:0] HASH_SQ_ADD = 32'd19990303;
   localparam logic [31:0] HASH_SUB    = 32'd771171059;
   localparam int HASH_LAT = 4;

   // weights are unsigned q16 in [0, 1]
   localparam int WEIGHT_W = 17;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << 16);

   // q30 constants
   localparam longint unsigned Q30 = 64'd1 << 30;
   localparam logic signed [31:0] CORNER_ONE = 32'sd1073741824;
   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam logic [29:0]     LN2_Q30 = 30'd744261118;

   // exponential series
   localparam int EXP_TERMS = 13;
   localparam int EXP_IN_W  = 33;
   localparam int TERM_W    = 31;
   localparam int ESUM_W    = 32;
   localparam int POW_W     = 38;
   localparam int EXP_LAT   = 2 * EXP_TERMS + 2;

   // divider
   localparam int QUO_W = OUT_FRAC_BITS + 1;
   localparam int NUM_W = POW_W + OUT_FRAC_BITS + 1;

   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef weight_type wtab_type [TABLE_SIZE];
   typedef logic [HASH_W-1:0] hash_type [CORNERS];

   // shift and subtract quotient, used only while building the table
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic longint cos_q30(input longint unsigned a);
      longint unsigned a2;
      longint unsigned term;
      longint sum;
      a2   = (a * a) >> 30;
      term = Q30;
      sum  = longint'(Q30);
      for (int k = 1; k <= 7; k++) begin
         term = udiv64((term * a2) >> 30, longint'((2 * k - 1) * (2 * k)));
         if ((k & 1) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > longint'(Q30)) begin
         sum = longint'(Q30);
      end
      return sum;
   endfunction

   // weight (1 - cos(pi*t))/2 in q16, built at elaboration
   function automatic wtab_type build_wtab();
      wtab_type tab;
      longint unsigned j;
      longint unsigned a;
      longint c;
      longint w;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         j = (i <= HALF_TABLE) ? longint'(i) : longint'(TABLE_SIZE - i);
         a = (j * PI_Q30 + longint'(HALF_TABLE)) >> COS_TABLE_BITS;
         c = cos_q30(a);
         // both halves are non-negative, so the shift is the halving
         w = (i <= HALF_TABLE) ? (longint'(Q30) - c) >>> 1 : (longint'(Q30) + c) >>> 1;
         tab[i] = WEIGHT_W'((longint'(w) + 8192) >>> 14);
      end
      return tab;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/vns_hash.sv =====
`default_nettype none

module vns_hash (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [vns_pkg::IPART_W-1:0]   in_xi,
   input  logic [vns_pkg::IPART_W-1:0]   in_yi,
   output logic                          out_valid,
   output vns_pkg::hash_type             out_hash
);
   import vns_pkg::*;

   logic [HASH_LAT-1:0] valid_ff;
   logic [31:0] cx [CORNERS];
   logic [31:0] cy [CORNERS];
   logic [31:0] n0 [CORNERS];
   logic [31:0] h1_n_in  [CORNERS];
   logic [31:0] h1_n_ff  [CORNERS];
   logic [31:0] h2_n_ff  [CORNERS];
   logic [31:0] h2_sq_ff [CORNERS];
   logic [31:0] h3_n_ff  [CORNERS];
   logic [31:0] h3_t_ff  [CORNERS];
   logic [HASH_W-1:0] h4_h_ff [CORNERS];

   // corner order: (x,y) (x+1,y) (x,y+1) (x+1,y+1)
   always_comb begin
      cx[0] = in_xi;
      cx[1] = in_xi + 32'd1;
      cx[2] = in_xi;
      cx[3] = in_xi + 32'd1;
      cy[0] = in_yi;
      cy[1] = in_yi;
      cy[2] = in_yi + 32'd1;
      cy[3] = in_yi + 32'd1;
      for (int i = 0; i < CORNERS; i++) begin
         n0[i]      = cx[i] + 32'(cy[i] * HASH_Y_MUL);
         h1_n_in[i] = (n0[i] << HASH_SHIFT) ^ n0[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[HASH_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CORNERS; i++) begin
         h1_n_ff[i]  <= h1_n_in[i];
         h2_n_ff[i]  <= h1_n_ff[i];
         h2_sq_ff[i] <= 32'(h1_n_ff[i] * h1_n_ff[i]);
         h3_n_ff[i]  <= h2_n_ff[i];
         h3_t_ff[i]  <= 32'(h2_sq_ff[i] * HASH_SQ_MUL) + HASH_SQ_ADD;
         h4_h_ff[i]  <= HASH_W'(32'(h3_n_ff[i] * h3_t_ff[i]) - HASH_SUB);
      end
   end

   assign out_valid = valid_ff[HASH_LAT-1];
   assign out_hash  = h4_h_ff;

endmodule

`default_nettype wire

// ===== hdl/vns_exp.sv =====
`default_nettype none

module vns_exp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [vns_pkg::EXP_IN_W-1:0]  in_arg,
   input  logic                          in_tag,
   output logic                          out_valid,
   output logic [vns_pkg::POW_W-1:0]     out_pow,
   output logic                          out_tag
);
   import vns_pkg::*;

   // entry stage: y = frac * ln2, integer part kept for the final shift
   logic                valid0_ff;
   logic [29:0]         y0_ff;
   logic [2:0]          n0_ff;
   logic                tag0_ff;
   logic [29:0]         y0_in;

   assign y0_in = 30'((60'(in_arg[29:0]) * 60'(LN2_Q30)) >> 30);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else begin
         valid0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      y0_ff   <= y0_in;
      n0_ff   <= in_arg[EXP_IN_W-1:30];
      tag0_ff <= in_tag;
   end

   // two stages per series term: multiply by y, then divide by k
   logic              a_valid_ff [EXP_TERMS];
   logic [TERM_W-1:0] a_t_ff     [EXP_TERMS];
   logic [ESUM_W-1:0] a_e_ff     [EXP_TERMS];
   logic [29:0]       a_y_ff     [EXP_TERMS];
   logic [2:0]        a_n_ff     [EXP_TERMS];
   logic              a_tag_ff   [EXP_TERMS];
   logic              b_valid_ff [EXP_TERMS];
   logic [TERM_W-1:0] b_term_ff  [EXP_TERMS];
   logic [ESUM_W-1:0] b_e_ff     [EXP_TERMS];
   logic [29:0]       b_y_ff     [EXP_TERMS];
   logic [2:0]        b_n_ff     [EXP_TERMS];
   logic              b_tag_ff   [EXP_TERMS];

   logic              src_valid [EXP_TERMS];
   logic [TERM_W-1:0] src_term  [EXP_TERMS];
   logic [ESUM_W-1:0] src_e     [EXP_TERMS];
   logic [29:0]       src_y     [EXP_TERMS];
   logic [2:0]        src_n     [EXP_TERMS];
   logic              src_tag   [EXP_TERMS];

   for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
      localparam int K = j + 1;
      localparam int SH = TERM_W + $clog2(K);
      localparam longint unsigned RCP = ((64'd1 << SH) + longint'(K) - 1) / longint'(K);

      if (j == 0) begin : g_first
         // series starts with term 1 and an empty sum
         assign src_valid[j] = valid0_ff;
         assign src_term[j]  = TERM_W'(Q30);
         assign src_e[j]     = '0;
         assign src_y[j]     = y0_ff;
         assign src_n[j]     = n0_ff;
         assign src_tag[j]   = tag0_ff;
      end else begin : g_next
         assign src_valid[j] = b_valid_ff[j-1];
         assign src_term[j]  = b_term_ff[j-1];
         assign src_e[j]     = b_e_ff[j-1];
         assign src_y[j]     = b_y_ff[j-1];
         assign src_n[j]     = b_n_ff[j-1];
         assign src_tag[j]   = b_tag_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff[j] <= 1'b0;
            b_valid_ff[j] <= 1'b0;
         end else begin
            a_valid_ff[j] <= src_valid[j];
            b_valid_ff[j] <= a_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         a_t_ff[j]    <= TERM_W'((61'(src_term[j]) * 61'(src_y[j])) >> 30);
         a_e_ff[j]    <= src_e[j] + ESUM_W'(src_term[j]);
         a_y_ff[j]    <= src_y[j];
         a_n_ff[j]    <= src_n[j];
         a_tag_ff[j]  <= src_tag[j];
         // exact floor division by k through a reciprocal
         b_term_ff[j] <= TERM_W'((64'(a_t_ff[j]) * 64'(32'(RCP))) >> SH);
         b_e_ff[j]    <= a_e_ff[j];
         b_y_ff[j]    <= a_y_ff[j];
         b_n_ff[j]    <= a_n_ff[j];
         b_tag_ff[j]  <= a_tag_ff[j];
      end
   end

   // final stage: add last term and scale by the integer power of two
   logic              f_valid_ff;
   logic [POW_W-1:0]  f_pow_ff;
   logic              f_tag_ff;
   logic [ESUM_W-1:0] e_last;

   assign e_last = b_e_ff[EXP_TERMS-1] + ESUM_W'(b_term_ff[EXP_TERMS-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= b_valid_ff[EXP_TERMS-1];
      end
   end

   always_ff @(posedge clock) begin
      f_pow_ff <= POW_W'(e_last) << b_n_ff[EXP_TERMS-1];
      f_tag_ff <= b_tag_ff[EXP_TERMS-1];
   end

   assign out_valid = f_valid_ff;
   assign out_pow   = f_pow_ff;
   assign out_tag   = f_tag_ff;

endmodule

`default_nettype wire

// ===== hdl/vns_div.sv =====
`default_nettype none

module vns_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [vns_pkg::NUM_W-1:0]   in_num,
   input  logic [vns_pkg::POW_W-1:0]   in_den,
   input  logic                        in_tag,
   output logic                        out_valid,
   output logic [vns_pkg::QUO_W-1:0]   out_quo,
   output logic                        out_tag
);
   import vns_pkg::*;

   logic             valid_ff [QUO_W];
   logic [NUM_W-1:0] rem_ff   [QUO_W];
   logic [POW_W-1:0] den_ff   [QUO_W];
   logic [QUO_W-1:0] quo_ff   [QUO_W];
   logic             tag_ff   [QUO_W];

   // restoring division, one quotient bit per stage, msb first
   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      localparam int BIT = QUO_W - 1 - i;
      logic             v_src;
      logic [NUM_W-1:0] rem_src;
      logic [POW_W-1:0] den_src;
      logic [QUO_W-1:0] quo_src;
      logic             tag_src;
      logic [NUM_W-1:0] cand;
      logic [NUM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      if (i == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = in_num;
         assign den_src = in_den;
         assign quo_src = '0;
         assign tag_src = in_tag;
      end else begin : g_next
         assign v_src   = valid_ff[i-1];
         assign rem_src = rem_ff[i-1];
         assign den_src = den_ff[i-1];
         assign quo_src = quo_ff[i-1];
         assign tag_src = tag_ff[i-1];
      end

      always_comb begin
         cand   = NUM_W'(den_src) << BIT;
         rem_in = rem_src;
         quo_in = quo_src;
         if (rem_src >= cand) begin
            rem_in      = rem_src - cand;
            quo_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
         den_ff[i] <= den_src;
         quo_ff[i] <= quo_in;
         tag_ff[i] <= tag_src;
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_tag   = tag_ff[QUO_W-1];

endmodule

`default_nettype wire

// ===== hdl/value_noise_2d_sigmoid_unit.sv =====
`default_nettype none
`include "value_noise_2d_sigmoid_unit_macros.svh"

// 2d value noise with cosine blending and sigmoid shaping. A coordinate pair
// (signed, 16 fraction bits) is taken whenever start is high and busy is low;
// busy is only raised during reset, so a new word can enter on every clock.
// The unit is a fixed pipeline: each result shows up on rsp_noise_value with
// rsp_strobe high for exactly one cycle, and results leave in request order.
// There is no output backpressure: the receiver must take every result in the
// cycle it appears. The pipeline holds 3 input/split/table stages, 4 hash
// stages, 5 blend stages, 28 stages of the exponential series (two per term),
// 1 stage to form the ratio, 17 one-bit divider stages and the output
// register.
module value_noise_2d_sigmoid_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [vns_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [vns_pkg::COORD_W-1:0]  req_coord_y,
   output logic                                rsp_strobe,
   output logic signed [vns_pkg::OUT_W-1:0]    rsp_noise_value
);
   import vns_pkg::*;

   localparam int TAB_IDX_W = COS_TABLE_BITS;
   localparam wtab_type WTAB = build_wtab();
   localparam longint OUT_LIMIT = longint'(1) << OUT_FRAC_BITS;

   logic accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   // ---------------------------------------------------------------
   // stage 0: capture request word
   // ---------------------------------------------------------------
   logic               s0_valid_ff;
   logic [COORD_W-1:0] s0_x_ff;
   logic [COORD_W-1:0] s0_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s0_x_ff <= req_coord_x;
      s0_y_ff <= req_coord_y;
   end

   // ---------------------------------------------------------------
   // stage 1: sign and magnitude of each coordinate
   // ---------------------------------------------------------------
   logic               s1_valid_ff;
   logic               s1_xneg_ff, s1_yneg_ff;
   logic [COORD_W-1:0] s1_xmag_ff, s1_ymag_ff;
   logic [COORD_W-1:0] s1_xmag_in, s1_ymag_in;

   assign s1_xmag_in = s0_x_ff[COORD_W-1] ? -s0_x_ff : s0_x_ff;
   assign s1_ymag_in = s0_y_ff[COORD_W-1] ? -s0_y_ff : s0_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_xneg_ff <= s0_x_ff[COORD_W-1];
      s1_yneg_ff <= s0_y_ff[COORD_W-1];
      s1_xmag_ff <= s1_xmag_in;
      s1_ymag_ff <= s1_ymag_in;
   end

   // ---------------------------------------------------------------
   // stage 2: truncated integer part (mod 2^32) and weight table read
   // ---------------------------------------------------------------
   logic                 s2_valid_ff;
   logic [IPART_W-1:0]   s2_xi_ff, s2_yi_ff;
   weight_type           s2_wx_ff, s2_wy_ff;
   logic [IPART_W-1:0]   xip, yip;
   logic [TAB_IDX_W-1:0] xidx, yidx;

   assign xip = IPART_W'(s1_xmag_ff >> COORD_FRAC_BITS);
   assign yip = IPART_W'(s1_ymag_ff >> COORD_FRAC_BITS);
   // fraction magnitude aligned to the table index, whichever is finer
   assign xidx = TAB_IDX_W'({s1_xmag_ff[COORD_FRAC_BITS-1:0], {TAB_IDX_W{1'b0}}}
                            >> COORD_FRAC_BITS);
   assign yidx = TAB_IDX_W'({s1_ymag_ff[COORD_FRAC_BITS-1:0], {TAB_IDX_W{1'b0}}}
                            >> COORD_FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_xi_ff <= s1_xneg_ff ? -xip : xip;
      s2_yi_ff <= s1_yneg_ff ? -yip : yip;
      s2_wx_ff <= WTAB[xidx];
      s2_wy_ff <= WTAB[yidx];
   end

   // ---------------------------------------------------------------
   // corner hashes, weights ride alongside
   // ---------------------------------------------------------------
   logic       hash_valid;
   hash_type   hash_val;
   weight_type wx_dly_ff [HASH_LAT];
   weight_type wy_dly_ff [HASH_LAT];

   vns_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_xi     (s2_xi_ff),
      .in_yi     (s2_yi_ff),
      .out_valid (hash_valid),
      .out_hash  (hash_val)
   );

   always_ff @(posedge clock) begin
      wx_dly_ff[0] <= s2_wx_ff;
      wy_dly_ff[0] <= s2_wy_ff;
      for (int i = 1; i < HASH_LAT; i++) begin
         wx_dly_ff[i] <= wx_dly_ff[i-1];
         wy_dly_ff[i] <= wy_dly_ff[i-1];
      end
   end

   // ---------------------------------------------------------------
   // blend stage 1: corner values times x weights
   // ---------------------------------------------------------------
   logic               b1_valid_ff;
   logic signed [49:0] b1_p_ff [CORNERS];
   logic signed [49:0] b1_p_in [CORNERS];
   logic signed [31:0] corner  [CORNERS];
   weight_type         b1_wy_ff;
   weight_type         wx, wxc;

   always_comb begin
      wx  = wx_dly_ff[HASH_LAT-1];
      wxc = WEIGHT_ONE - wx;
      for (int i = 0; i < CORNERS; i++) begin
         corner[i] = CORNER_ONE - $signed({1'b0, hash_val[i]});
      end
      b1_p_in[0] = corner[0] * $signed({1'b0, wxc});
      b1_p_in[1] = corner[1] * $signed({1'b0, wx});
      b1_p_in[2] = corner[2] * $signed({1'b0, wxc});
      b1_p_in[3] = corner[3] * $signed({1'b0, wx});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= hash_valid;
      end
   end

   always_ff @(posedge clock) begin
      b1_p_ff  <= b1_p_in;
      b1_wy_ff <= wy_dly_ff[HASH_LAT-1];
   end

   // ---------------------------------------------------------------
   // blend stage 2: top and bottom rows
   // ---------------------------------------------------------------
   logic               b2_valid_ff;
   logic signed [49:0] b2_top_ff, b2_bot_ff;
   weight_type         b2_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else begin
         b2_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b2_top_ff <= b1_p_ff[0] + b1_p_ff[1];
      b2_bot_ff <= b1_p_ff[2] + b1_p_ff[3];
      b2_wy_ff  <= b1_wy_ff;
   end

   // ---------------------------------------------------------------
   // blend stage 3: rows times y weights (q62 parts)
   // ---------------------------------------------------------------
   logic               b3_valid_ff;
   logic signed [63:0] b3_top_ff, b3_bot_ff;
   logic signed [67:0] b3_top_in, b3_bot_in;
   weight_type         wyc;

   assign wyc       = WEIGHT_ONE - b2_wy_ff;
   assign b3_top_in = b2_top_ff * $signed({1'b0, wyc});
   assign b3_bot_in = b2_bot_ff * $signed({1'b0, b2_wy_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_valid_ff <= 1'b0;
      end else begin
         b3_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b3_top_ff <= b3_top_in[63:0];
      b3_bot_ff <= b3_bot_in[63:0];
   end

   // ---------------------------------------------------------------
   // blend stage 4: sum and round q62 to q30, half up
   // ---------------------------------------------------------------
   logic               b4_valid_ff;
   logic signed [31:0] b4_v30_ff;
   logic signed [63:0] v62_rnd;

   assign v62_rnd = b3_top_ff + b3_bot_ff + 64'sd2147483648;

   always_ff @(posedge clock) begin
      if (reset) begin
         b4_valid_ff <= 1'b0;
      end else begin
         b4_valid_ff <= b3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b4_v30_ff <= v62_rnd[63:32];
   end

   // ---------------------------------------------------------------
   // blend stage 5: 6*|v| as the exponent, sign kept for the end
   // ---------------------------------------------------------------
   logic                b5_valid_ff;
   logic [EXP_IN_W-1:0] b5_arg_ff;
   logic                b5_neg_ff;
   logic [30:0]         vmag;

   assign vmag = b4_v30_ff[31] ? 31'(-b4_v30_ff) : 31'(b4_v30_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b5_valid_ff <= 1'b0;
      end else begin
         b5_valid_ff <= b4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b5_arg_ff <= EXP_IN_W'({vmag, 2'b00}) + EXP_IN_W'({vmag, 1'b0});
      b5_neg_ff <= b4_v30_ff[31];
   end

   // ---------------------------------------------------------------
   // 2^(6|v|) in q30
   // ---------------------------------------------------------------
   logic             exp_valid;
   logic [POW_W-1:0] exp_pow;
   logic             exp_neg;

   vns_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b5_valid_ff),
      .in_arg    (b5_arg_ff),
      .in_tag    (b5_neg_ff),
      .out_valid (exp_valid),
      .out_pow   (exp_pow),
      .out_tag   (exp_neg)
   );

   // ---------------------------------------------------------------
   // ratio operands: (p - 1) << frac + (p + 1)/2 over (p + 1)
   // ---------------------------------------------------------------
   logic             d0_valid_ff;
   logic [NUM_W-1:0] d0_num_ff;
   logic [POW_W-1:0] d0_den_ff;
   logic             d0_neg_ff;
   logic [POW_W-1:0] den_in;

   assign den_in = exp_pow + POW_W'(Q30);

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_valid_ff <= 1'b0;
      end else begin
         d0_valid_ff <= exp_valid;
      end
   end

   always_ff @(posedge clock) begin
      d0_num_ff <= (NUM_W'(exp_pow - POW_W'(Q30)) << OUT_FRAC_BITS)
                   + NUM_W'(den_in >> 1);
      d0_den_ff <= den_in;
      d0_neg_ff <= exp_neg;
   end

   logic             div_valid;
   logic [QUO_W-1:0] div_quo;
   logic             div_neg;

   vns_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d0_valid_ff),
      .in_num    (d0_num_ff),
      .in_den    (d0_den_ff),
      .in_tag    (d0_neg_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_tag   (div_neg)
   );

   // ---------------------------------------------------------------
   // output word: sign applied last, masked to the port width
   // ---------------------------------------------------------------
   logic                    out_valid_ff;
   logic signed [OUT_W-1:0] out_value_ff;
   logic [QUO_W:0]          quo_ext;

   assign quo_ext = {1'b0, div_quo};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= div_neg ? OUT_W'(-quo_ext) : OUT_W'(quo_ext);
   end

   assign rsp_strobe      = out_valid_ff;
   assign rsp_noise_value = out_value_ff;

   // checks
   `VNS_ASSERT_IMPLY(a_blend_range, clock, reset, b4_valid_ff,
      (b4_v30_ff >= -32'sd1073741824) && (b4_v30_ff <= 32'sd1073741824))
   `VNS_ASSERT_IMPLY(a_pow_floor, clock, reset, exp_valid,
      (exp_pow >= POW_W'(Q30)))
   `VNS_ASSERT_IMPLY(a_quo_range, clock, reset, div_valid,
      (longint'(div_quo) <= OUT_LIMIT))
   `VNS_ASSERT_IMPLY(a_out_range, clock, reset, rsp_strobe,
      (longint'(rsp_noise_value) <= OUT_LIMIT) && (longint'(rsp_noise_value) >= -OUT_LIMIT))

endmodule

`default_nettype wire

// ===== verif/tb_value_noise_2d_sigmoid_unit.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_value_noise_2d_sigmoid_unit;
   import vns_pkg::*;

   localparam int LAT         = 59;
   localparam int STALL_LIMIT = 2000;
   localparam int NUM_RANDOM  = 1900;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [COORD_W-1:0] req_coord_x;
   logic signed [COORD_W-1:0] req_coord_y;
   logic rsp_strobe;
   logic signed [OUT_W-1:0] rsp_noise_value;

   value_noise_2d_sigmoid_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .rsp_strobe(rsp_strobe), .rsp_noise_value(rsp_noise_value)
   );

   // one pending coordinate word with its idle gap
   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      int                 gap;
   } coord_word_type;

   coord_word_type     coord_q [$];
   logic [OUT_W-1:0]   noise_expected_q [$];
   longint unsigned    blend_weight [TABLE_SIZE];

   int  mismatch_cnt = 0;
   int  stall_cnt = 0;
   bit  fill_done = 0;
   bit  timed_out = 0;
   int  gap_left = 0;
   bit  have_word = 0;

   // cosine by truncating taylor series in q30
   function automatic longint unsigned cosine_q30(longint unsigned ang);
      longint unsigned sq;
      longint unsigned term;
      longint acc;
      sq = (ang * ang) >> 30;
      term = 64'd1 << 30;
      acc = 64'sd1 << 30;
      for (int k = 1; k <= 7; k++) begin
         term = ((term * sq) >> 30) / longint'((2 * k - 1) * (2 * k));
         if (k & 1) acc -= longint'(term);
         else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
      return longint'(acc);
   endfunction

   function automatic void fill_blend_table();
      longint unsigned j;
      longint unsigned ang;
      longint c;
      longint w;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         j = (i <= TABLE_SIZE / 2) ? i : TABLE_SIZE - i;
         ang = (j * 64'd3373259426 + TABLE_SIZE / 2) >> COS_TABLE_BITS;
         c = longint'(cosine_q30(ang));
         w = (i <= TABLE_SIZE / 2) ? ((64'sd1 << 30) - c) / 2 : ((64'sd1 << 30) + c) / 2;
         blend_weight[i] = (longint'(w) + 8192) >> 14;
      end
   endfunction

   // truncate toward zero, weight from fraction magnitude
   function automatic void split_axis(input logic [COORD_W-1:0] raw,
                                      output logic [31:0] ip,
                                      output longint weight);
      logic [COORD_W-1:0] mag;
      logic [COORD_W-1:0] ipm;
      logic [COORD_FRAC_BITS-1:0] fr;
      mag = raw[COORD_W-1] ? -raw : raw;
      ipm = mag >> COORD_FRAC_BITS;
      fr = mag[COORD_FRAC_BITS-1:0];
      ip = raw[COORD_W-1] ? -ipm[31:0] : ipm[31:0];
      weight = longint'(blend_weight[fr >> (COORD_FRAC_BITS - COS_TABLE_BITS)]);
   endfunction

   function automatic longint lattice_value(logic [31:0] xi, logic [31:0] yi);
      logic [31:0] n;
      logic [31:0] h;
      n = xi + 32'd57 * yi;
      n = (n << 13) ^ n;
      h = (n * (32'd60493 * n * n + 32'd19990303) - 32'd771171059) & 32'h7FFFFFFF;
      return (64'sd1 << 30) - longint'({32'd0, h});
   endfunction

   function automatic longint unsigned pow2_q30(longint unsigned a);
      longint unsigned n;
      longint unsigned y;
      longint unsigned term;
      longint unsigned e;
      n = a >> 30;
      y = ((a & ((64'd1 << 30) - 1)) * 64'd744261118) >> 30;
      term = 64'd1 << 30;
      e = term;
      for (int k = 1; k <= 13; k++) begin
         term = ((term * y) >> 30) / k;
         e += term;
      end
      return e << (n & 7);
   endfunction

   function automatic logic [OUT_W-1:0] predict_noise(logic [COORD_W-1:0] cx,
                                                      logic [COORD_W-1:0] cy);
      logic [31:0] xi, yi;
      longint wx, wy, top, bot, v62, v30, res;
      longint unsigned u, mag, p, num, den, r;
      split_axis(cx, xi, wx);
      split_axis(cy, yi, wy);
      top = lattice_value(xi, yi) * (65536 - wx) + lattice_value(xi + 1, yi) * wx;
      bot = lattice_value(xi, yi + 1) * (65536 - wx) + lattice_value(xi + 1, yi + 1) * wx;
      v62 = top * (65536 - wy) + bot * wy;
      u = longint'(v62) + (64'd1 << 62) + (64'd1 << 31);
      v30 = longint'(u >> 32) - (64'sd1 << 30);
      mag = v30 < 0 ? -v30 : v30;
      p = pow2_q30(6 * mag);
      num = (p - (64'd1 << 30)) << OUT_FRAC_BITS;
      den = p + (64'd1 << 30);
      r = (num + den / 2) / den;
      res = v30 < 0 ? -longint'(r) : longint'(r);
      return res[OUT_W-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      logic [COORD_W-1:0] v;
      v = COORD_W'({$urandom, $urandom});
      case ($urandom_range(0, 3))
         0: v = {{(COORD_W-26){v[25]}}, v[25:0]};            // near origin
         1: v = {{(COORD_W-36){v[35]}}, v[35:0]};
         default: ;                                          // full range
      endcase
      return v;
   endfunction

   task automatic push_word(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      coord_word_type w;
      w.x = x;
      w.y = y;
      w.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 1)) w.gap = 0;   // back-to-back stretches
      coord_q.push_back(w);
   endtask

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (7) @(posedge clock);
      reset <= 0;
   end

   // stimulus
   initial begin
      logic [COORD_W-1:0] mx, mn;
      fill_blend_table();
      mx = {1'b0, {(COORD_W-1){1'b1}}};
      mn = {1'b1, {(COORD_W-1){1'b0}}};
      push_word('0, '0);
      push_word(mx, mx);
      push_word(mn, mn);
      push_word(mx, mn);
      push_word(mn, mx);
      push_word('1, '1);                                      // tiny negative fraction
      push_word(48'h0000_0000_8000, 48'h0000_0000_8000);      // half weight
      push_word(-48'sh0000_0000_8000, 48'h0000_0000_4000);
      push_word(-48'sh0001_0000, -48'sh0003_C000);            // negative integer parts
      push_word(48'h0000_FFFF_FFFF, 48'h0000_0000_FFFF);      // all-ones fraction, ipart 0xFFFF
      push_word(48'h7FFF_0000_0000, 48'h0000_FFFF_0000);
      push_word(48'h0000_0000_003F, 48'h0000_0000_0040);      // table index edges
      push_word(48'h0000_0000_FFC0, 48'h0000_0000_FFFF);
      push_word(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
      push_word(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
      for (int i = 0; i < 8; i++) push_word(COORD_W'($urandom_range(0, 20) << 14),
                                            COORD_W'($urandom_range(0, 20) << 14));
      for (int i = 0; i < NUM_RANDOM; i++) push_word(rand_coord(), rand_coord());
      fill_done = 1;
   end

   // driver: start held high across back-to-back words
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         req_coord_x <= '0;
         req_coord_y <= '0;
         have_word <= 0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            noise_expected_q.push_back(predict_noise(req_coord_x, req_coord_y));
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               start <= 0;
               gap_left <= gap_left - 1;
            end else if (coord_q.size() > 0) begin
               coord_word_type w;
               w = coord_q.pop_front();
               req_coord_x <= w.x;
               req_coord_y <= w.y;
               start <= 1;
               gap_left <= w.gap;
            end else begin
               start <= 0;
            end
         end
      end
   end

   // monitor: every strobed word checked against oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (noise_expected_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("unexpected noise word %h", rsp_noise_value);
         end else begin
            logic [OUT_W-1:0] exp_v;
            exp_v = noise_expected_q.pop_front();
            if (rsp_noise_value !== exp_v) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("noise mismatch: expected %h actual %h", exp_v, rsp_noise_value);
            end
         end
      end
   end

   // watchdog on cycles with no accepted word on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) timed_out = 1;
   end

   initial begin
      @(negedge reset);
      wait ((fill_done && coord_q.size() == 0 && !start && noise_expected_q.size() == 0)
            || timed_out);
      if (!timed_out) begin
         repeat (LAT + 10) @(posedge clock);
      end
      if (timed_out) begin
         $display("CHECKS FAILED");
      end else if (mismatch_cnt == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
